### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sss_pkg.sv
package sss_pkg;

  localparam int MAX_SAMPLES_DEF = 16;
  localparam int SAMPLE_W        = 16;
  localparam int FRAC_BITS       = 16;
  localparam int MEAN_W          = 32;
  localparam int VAR_W           = 47;
  localparam int COUNT_OUT_W     = 5;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_PROD,
    ST_MEAN,
    ST_VAR,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;
    logic load_prod;
    logic div_start;
    logic div_var;
    logic take_mean;
    logic take_var;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

### hdl/sss_div.sv
`include "assert_macros.svh"

module sss_div #(
  parameter int DW = 56,
  parameter int VW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;
  logic [VW-1:0] rem_next;

  // One restoring step per cycle, dividend bits shifted in from the top.
  always_comb begin
    trial    = {rem, quo[DW-1]};
    diff     = trial - {1'b0, dvs};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(DW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[DW-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

  `CHK_NOW(a_no_restart, clk, rst, start, !running, "divider started while still running")

endmodule

### hdl/sss_dp.sv
`include "assert_macros.svh"

module sss_dp #(
  parameter int MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sss_pkg::cmd_t                        cmd,
  output sss_pkg::stat_t                       stat,
  input  logic signed [sss_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [sss_pkg::SAMPLE_W-1:0]  max_value,
  output logic signed [sss_pkg::SAMPLE_W-1:0]  min_value,
  output logic signed [sss_pkg::MEAN_W-1:0]    mean_fixed,
  output logic [sss_pkg::VAR_W-1:0]            variance_fixed,
  output logic [sss_pkg::COUNT_OUT_W-1:0]      sample_count,
  output logic                                 too_many
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = sss_pkg::SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int SQ_W   = 2 * sss_pkg::SAMPLE_W - 1 + $clog2(MAX_SAMPLES);
  localparam int LHS_W  = CNT_W + SQ_W;
  localparam int RHS_W  = 2 * SUM_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int DIV_W  = LHS_W + sss_pkg::FRAC_BITS;
  localparam int DVS_W  = 2 * CNT_W;
  localparam int SQS_W  = 2 * sss_pkg::SAMPLE_W;

  // Accumulators for the set being collected.
  logic [CNT_W-1:0]                   count;
  logic signed [sss_pkg::SAMPLE_W-1:0] running_max;
  logic signed [sss_pkg::SAMPLE_W-1:0] running_min;
  logic signed [SUM_W-1:0]            running_sum;
  logic [SQ_W-1:0]                    running_square_sum;
  logic                               overflowed;

  // Back end registers.
  logic [LHS_W-1:0]                   lhs;
  logic [RHS_W-1:0]                   rhs;
  logic [DVS_W-1:0]                   n_sq;
  logic [LHS_W-1:0]                   diff;
  logic                               sum_neg;
  logic signed [sss_pkg::MEAN_W-1:0]  mean_r;
  logic [sss_pkg::VAR_W-1:0]          var_r;

  logic signed [SQS_W-1:0]            sample_sq;
  logic [SUM_W-1:0]                   abs_now;
  logic [CMP_W-1:0]                   lhs_x;
  logic [CMP_W-1:0]                   rhs_x;
  logic [CMP_W-1:0]                   sub_x;
  logic [DIV_W-1:0]                   div_dividend;
  logic [DVS_W-1:0]                   div_divisor;
  logic [DIV_W-1:0]                   div_quotient;
  logic                               div_done;
  logic [sss_pkg::MEAN_W-1:0]         mean_mag;

  always_comb begin
    sample_sq = sample * sample;
    abs_now   = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
    lhs_x     = CMP_W'(lhs);
    rhs_x     = CMP_W'(rhs);
    sub_x     = lhs_x - rhs_x;
    mean_mag  = div_quotient[sss_pkg::MEAN_W-1:0];
    if (cmd.div_var) begin
      div_dividend = {diff, {sss_pkg::FRAC_BITS{1'b0}}};
      div_divisor  = n_sq;
    end else begin
      div_dividend = DIV_W'({abs_now, {sss_pkg::FRAC_BITS{1'b0}}});
      div_divisor  = DVS_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count              <= '0;
      running_max        <= '0;
      running_min        <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      overflowed         <= 1'b0;
    end else if (cmd.accum) begin
      if (count == CNT_W'(MAX_SAMPLES)) begin
        overflowed <= 1'b1;
      end else begin
        if (count == '0 || sample > running_max) begin
          running_max <= sample;
        end
        if (count == '0 || sample < running_min) begin
          running_min <= sample;
        end
        running_sum        <= running_sum + SUM_W'(sample);
        running_square_sum <= running_square_sum + SQ_W'(sample_sq[SQS_W-2:0]);
        count              <= count + 1'b1;
      end
    end
  end

  // Products are taken once the set is closed, then the difference settles
  // long before the variance division is started.
  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      lhs     <= LHS_W'(count) * LHS_W'(running_square_sum);
      rhs     <= RHS_W'(abs_now) * RHS_W'(abs_now);
      n_sq    <= DVS_W'(count) * DVS_W'(count);
      sum_neg <= running_sum[SUM_W-1];
    end
    diff <= (lhs_x > rhs_x) ? sub_x[LHS_W-1:0] : '0;
    if (cmd.take_mean) begin
      mean_r <= sum_neg ? -mean_mag : mean_mag;
    end
    if (cmd.take_var) begin
      var_r <= div_quotient[sss_pkg::VAR_W-1:0];
    end
  end

  sss_div #(
    .DW(DIV_W),
    .VW(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(div_quotient),
    .done    (div_done)
  );

  assign stat.div_done = div_done;

  assign max_value      = overflowed ? '0 : running_max;
  assign min_value      = overflowed ? '0 : running_min;
  assign mean_fixed     = overflowed ? '0 : mean_r;
  assign variance_fixed = overflowed ? '0 : var_r;
  assign sample_count   = sss_pkg::COUNT_OUT_W'(count);
  assign too_many       = overflowed;

  `CHK_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_SAMPLES), "count past bound")

endmodule

### hdl/sss_ctrl.sv
`include "assert_macros.svh"

module sss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last,
  input  sss_pkg::stat_t stat,
  output sss_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  sss_pkg::state_t state;
  sss_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sss_pkg::ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      sss_pkg::ST_ACCUM: begin
        busy = 1'b0;
        if (start) begin
          cmd.accum = 1'b1;
          if (last) begin
            state_next = sss_pkg::ST_PROD;
          end
        end
      end
      sss_pkg::ST_PROD: begin
        cmd.load_prod = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = sss_pkg::ST_MEAN;
      end
      sss_pkg::ST_MEAN: begin
        if (stat.div_done) begin
          cmd.take_mean = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_var   = 1'b1;
          state_next    = sss_pkg::ST_VAR;
        end
      end
      sss_pkg::ST_VAR: begin
        if (stat.div_done) begin
          cmd.take_var = 1'b1;
          state_next   = sss_pkg::ST_OUT;
        end
      end
      sss_pkg::ST_OUT: begin
        done       = 1'b1;
        cmd.clear  = 1'b1;
        state_next = sss_pkg::ST_ACCUM;
      end
      default: begin
        state_next = sss_pkg::ST_ACCUM;
      end
    endcase
  end

  `CHK_NEXT(a_done_single, clk, rst, done, !done, "result strobe lasted more than a cycle")
  `CHK_NOW(a_done_busy, clk, rst, done, busy, "result strobe while accepting words")
  `CHK_NOW(a_div_idle, clk, rst, !busy, !stat.div_done, "divider finished while collecting")

endmodule

### hdl/sample_set_statistics.sv
// Set statistics: maximum, minimum, mean and population variance.
// Input channel: a word (sample, last) is taken at a rising edge where
// start is high and busy is low. Words can be taken one per cycle, and
// each is folded into the count, extremes, sum and sum of squares.
// The word with last also closes the set. The block then raises busy and runs
// its back end: the products are registered, then a shared one-bit-per-cycle
// divider produces the mean and then the variance. The divider is
// DIV_W bits wide, where DIV_W = clog2(MAX_SAMPLES+1) + 31
// + clog2(MAX_SAMPLES) + 16 (56 at the default bound of 16).
// Output channel: done is high for exactly one cycle once the variance
// result has been registered from the divider, and the
// result fields are valid in that cycle only. The receiver cannot stall
// the block; it must take the result in that cycle. Busy drops in the
// cycle after done, and the next set may begin then.
// A set longer than MAX_SAMPLES reports too_many with zero value fields.
// Reset is synchronous: it empties the accumulators, stops the divider
// and returns the block to collecting words with busy low.
module sample_set_statistics #(
  parameter int MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  output logic                                done,
  output logic signed [sss_pkg::SAMPLE_W-1:0] max_value,
  output logic signed [sss_pkg::SAMPLE_W-1:0] min_value,
  output logic signed [sss_pkg::MEAN_W-1:0]   mean_fixed,
  output logic [sss_pkg::VAR_W-1:0]           variance_fixed,
  output logic [sss_pkg::COUNT_OUT_W-1:0]     sample_count,
  output logic                                too_many
);

  sss_pkg::cmd_t  cmd;
  sss_pkg::stat_t stat;

  // Controller: sequences collection, products, both divisions, result.
  sss_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .last (last),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  // Datapath: accumulators, multipliers, divider and result registers.
  sss_dp #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .sample        (sample),
    .max_value     (max_value),
    .min_value     (min_value),
    .mean_fixed    (mean_fixed),
    .variance_fixed(variance_fixed),
    .sample_count  (sample_count),
    .too_many      (too_many)
  );

endmodule
